/* rtl/cpr_pkg.sv */
package cpr_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned PageIdW     = 8;
  localparam int unsigned FrameIndexW = 3;
  localparam int unsigned ActiveW     = 4;

  localparam logic [ActiveW-1:0] ActiveReset = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;    // latch a new item and rewind the lookup
    logic look;     // one lookup step over the tag memory
    logic sweep;    // one step of the clock hand
    logic publish;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit_found;  // the frame under compare holds the page
    logic scan_end;   // the last active frame has been compared
    logic ref_clear;  // the frame under the hand has a clear reference bit
    logic out_free;   // the output register can take a result
  } status_t;

endpackage

/* rtl/cpr_ram.sv */
module cpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cpr_ctrl.sv */
module cpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cpr_pkg::status_t status_i,
  output cpr_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        if (status_i.hit_found) begin
          state_d = S_DONE;
        end else if (status_i.scan_end) begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.ref_clear) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/cpr_datapath.sv */
module cpr_datapath #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [cpr_pkg::ActiveW-1:0]        cfg_data_i,
  input  logic [cpr_pkg::PageIdW-1:0]        page_id_i,
  input  cpr_pkg::cmd_t                      cmd_i,
  output cpr_pkg::status_t                   status_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               hit_o,
  output logic [cpr_pkg::FrameIndexW-1:0]    frame_index_o
);

  localparam int unsigned IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CntW = $clog2(FRAMES + 1);

  logic [cpr_pkg::ActiveW-1:0] active_q, active_d;
  logic [IdxW-1:0]             hand_q, hand_d;
  logic [FRAMES-1:0]           valid_q, valid_d;
  logic [FRAMES-1:0]           ref_q, ref_d;
  logic                        cmp_vld_q, cmp_vld_d;
  logic                        out_valid_q, out_valid_d;
  logic [PAGE_BITS-1:0]        page_q, page_d;
  logic [IdxW-1:0]             rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]             cmp_idx_q, cmp_idx_d;
  logic                        res_hit_q, res_hit_d;
  logic [IdxW-1:0]             res_idx_q, res_idx_d;
  logic                        hit_q, hit_d;
  logic [IdxW-1:0]             frame_q, frame_d;

  logic [CntW-1:0]      used_n;
  logic [IdxW-1:0]      last_idx;
  logic [IdxW-1:0]      hand_next;
  logic [PAGE_BITS-1:0] tag_rdata;
  logic                 tag_we;

  // A count of zero means one frame; a count above the built size saturates.
  always_comb begin
    if (active_q == '0) begin
      used_n = CntW'(1);
    end else if (32'(active_q) > 32'(FRAMES)) begin
      used_n = CntW'(FRAMES);
    end else begin
      used_n = CntW'(active_q);
    end
  end

  assign last_idx  = IdxW'(used_n - CntW'(1));
  assign hand_next = (hand_q == last_idx) ? '0 : hand_q + IdxW'(1);

  assign status_o.hit_found = cmp_vld_q && valid_q[cmp_idx_q] && (tag_rdata == page_q);
  assign status_o.scan_end  = cmp_vld_q && (cmp_idx_q == last_idx);
  assign status_o.ref_clear = !ref_q[hand_q];
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign tag_we = cmd_i.sweep && !ref_q[hand_q];

  cpr_ram #(
    .Width (PAGE_BITS),
    .Depth (FRAMES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (hand_q),
    .wdata_i (page_q),
    .raddr_i (rd_idx_q),
    .rdata_o (tag_rdata)
  );

  always_comb begin
    active_d    = active_q;
    hand_d      = hand_q;
    valid_d     = valid_q;
    ref_d       = ref_q;
    cmp_vld_d   = cmp_vld_q;
    out_valid_d = out_valid_q;
    page_d      = page_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    res_hit_d   = res_hit_q;
    res_idx_d   = res_idx_q;
    hit_d       = hit_q;
    frame_d     = frame_q;

    if (cfg_valid_i) begin
      active_d = cfg_data_i;
    end

    if (cmd_i.start) begin
      page_d    = PAGE_BITS'(page_id_i);
      rd_idx_d  = '0;
      cmp_vld_d = 1'b0;
      // The hand may point past the active frames after the count shrank.
      if (32'(hand_q) >= 32'(used_n)) begin
        hand_d = '0;
      end
    end

    // Reads are issued one frame ahead of the compare.
    if (cmd_i.look) begin
      cmp_idx_d = rd_idx_q;
      cmp_vld_d = 1'b1;
      if (rd_idx_q != last_idx) begin
        rd_idx_d = rd_idx_q + IdxW'(1);
      end
      if (status_o.hit_found) begin
        ref_d[cmp_idx_q] = 1'b1;
        res_hit_d        = 1'b1;
        res_idx_d        = cmp_idx_q;
      end
    end

    if (cmd_i.sweep) begin
      if (!ref_q[hand_q]) begin
        valid_d[hand_q] = 1'b1;
        ref_d[hand_q]   = 1'b1;
        res_hit_d       = 1'b0;
        res_idx_d       = hand_q;
      end else begin
        ref_d[hand_q] = 1'b0;
      end
      hand_d = hand_next;
    end

    if (cmd_i.publish) begin
      out_valid_d = 1'b1;
      hit_d       = res_hit_q;
      frame_d     = res_idx_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= cpr_pkg::ActiveReset;
      hand_q      <= '0;
      valid_q     <= '0;
      ref_q       <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      hand_q      <= hand_d;
      valid_q     <= valid_d;
      ref_q       <= ref_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    res_hit_q <= res_hit_d;
    res_idx_q <= res_idx_d;
    hit_q     <= hit_d;
    frame_q   <= frame_d;
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign frame_index_o = cpr_pkg::FrameIndexW'(frame_q);

endmodule

/* rtl/clock_page_replacement.sv */
// Clock (second-chance) page replacement.
//
// Input channel in_valid_i/in_ready_o carries one page access per item on
// page_id_i. Output channel out_valid_o/out_ready_i returns one result per
// item: hit_o and frame_index_o, the frame holding the page afterwards.
// The user must write the active frame count on cfg_valid_i/cfg_data_i only
// while idle; the block does not enforce it. cfg_ready_o is always high.
//
// Items are handled one at a time. The tag memory is scanned one frame per
// cycle with a registered read over the n active frames; a hit ends the scan.
// A miss then steps the clock hand one frame per cycle, at most n+1 steps,
// until a frame with a clear reference bit takes the page. The next item
// is taken the cycle after a result is loaded.
//
// Reset clears all valid and reference bits, the hand and the output valid
// flag and sets the active count to eight. Tags need no clearing. The output
// register holds a result while the receiver stalls; the next item is taken
// meanwhile and waits at its end until the register frees up.
module clock_page_replacement #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cpr_pkg::ActiveW-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cpr_pkg::PageIdW-1:0]     page_id_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o,
  output logic [cpr_pkg::FrameIndexW-1:0] frame_index_o
);

  cpr_pkg::cmd_t    cmd;
  cpr_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  cpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .page_id_i     (page_id_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .hit_o         (hit_o),
    .frame_index_o (frame_index_o)
  );

endmodule

/* rtl/cpr_checker.sv */
module cpr_checker #(
  parameter int unsigned FRAMES = 8
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            hit_o,
  input logic [cpr_pkg::FrameIndexW-1:0] frame_index_o
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(frame_index_o))
  else $error("stalled result changed");

  // Only one item is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
  else $error("second item taken while busy");

  // A result only appears at the end of an item's work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
  else $error("result appeared while idle");

  // The reported frame lies inside the built frames.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(frame_index_o) < FRAMES))
  else $error("frame index out of range");

endmodule

bind clock_page_replacement cpr_checker #(.FRAMES(FRAMES)) u_cpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .hit_o         (hit_o),
  .frame_index_o (frame_index_o)
);
